### hw/rtl/dipc_pkg.sv
// package: payload types, power mode codes and constants of the display idle power controller
package dipc_pkg;

  localparam int unsigned CFG_ADDR_W  = 4;
  localparam int unsigned CFG_DATA_W  = 32;
  localparam int unsigned TICK_W      = 16;
  localparam int unsigned PCT_W       = 7;

  localparam logic [TICK_W-1:0] DIM_AFTER_RESET  = 16'd60;
  localparam logic [TICK_W-1:0] OFF_AFTER_RESET  = 16'd240;
  localparam logic [PCT_W-1:0]  AWAKE_RESET      = 7'd100;
  localparam logic [PCT_W-1:0]  DIM_LEVEL        = 7'd20;
  localparam logic [PCT_W-1:0]  MIN_AWAKE        = 7'd10;
  localparam logic [PCT_W-1:0]  MAX_AWAKE        = 7'd100;
  localparam logic [TICK_W-1:0] IDLE_MAX         = 16'hFFFF;

  // register indexes, byte address is 4 * index
  typedef enum logic [1:0] {
    REG_DIM_AFTER = 2'd0,
    REG_OFF_AFTER = 2'd1,
    REG_AWAKE_PCT = 2'd2,
    REG_NONE      = 2'd3
  } reg_idx_t;

  typedef enum logic [1:0] {
    MODE_BRIGHT   = 2'd0,
    MODE_DIMMED   = 2'd1,
    MODE_OFF      = 2'd2,
    MODE_SLEEPING = 2'd3
  } power_mode_t;

  typedef enum logic [1:0] {
    WAKE_NONE = 2'd0,
    WAKE_PIN  = 2'd1,
    WAKE_BOOT = 2'd2,
    WAKE_USB  = 2'd3
  } wake_src_t;

  typedef struct packed {
    logic cmd;
    logic pmic_ok;
    logic usb_power;
    logic pin_wake;
    logic boot_pressed;
  } dipc_in_t;

  typedef struct packed {
    logic [PCT_W-1:0] brightness;
    logic             brightness_write;
    logic             save_request;
    logic             restart_request;
    logic             dozing;
    logic [1:0]       wake_source;
  } dipc_out_t;

endpackage

### hw/rtl/display_idle_power_controller.sv
// display idle power controller: idle counter, mode control and register port
//
// usage:
//   in_valid/in_ready carry one item per transfer: a poll tick (cmd 0) with the
//   power chip status and wake inputs, or a user activity report (cmd 1).
//   out_valid/out_ready carry exactly one result per item, in order: the
//   brightness to drive with its write strobe, save and restart requests,
//   the dozing flag and the wake source.
//   the APB-style port holds dim_after_ticks (0x0), off_after_ticks (0x4) and
//   awake_brightness (0x8, clamped to 10..100 on write); pready is always high.
// flow: an item is registered on transfer, evaluated against the mode
//   state once the result register is free or draining, and lands in the
//   result register, from which it leaves on an out_ready transfer.
// throughput: one item per cycle while out_ready is high; the mode state is
//   updated by one saturating 16-bit increment and two 16-bit compares.
// reset: rst_n (synchronous) empties both stages, sets the mode to bright,
//   clears the idle counter and the last usb flag, and loads register defaults.
// stall: while out_ready is low the result is held, the input stage still
//   takes one more item, and in_ready drops once both stages are full.
module display_idle_power_controller
  import dipc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  dipc_in_t              in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output dipc_out_t             out_data,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready
);

  logic [TICK_W-1:0] dim_after_r;
  logic [TICK_W-1:0] off_after_r;
  logic [PCT_W-1:0]  awake_pct_r;

  logic              s1_valid_r;
  dipc_in_t          s1_data_r;
  logic              out_valid_r;
  dipc_out_t         out_data_r;

  power_mode_t       mode_r, mode_nxt;
  logic [TICK_W-1:0] idle_r, idle_nxt;
  logic              last_usb_r, last_usb_nxt;

  logic              advance;
  logic              cfg_wr;
  reg_idx_t          cfg_idx;
  logic [PCT_W-1:0]  wr_pct;
  logic [PCT_W-1:0]  wr_pct_clamped;

  logic [TICK_W-1:0] idle_inc;
  logic              below_dim;
  logic              below_off;
  logic              stay_awake;
  wake_src_t         wake_src;
  dipc_out_t         res;

  // register port
  assign pready   = 1'b1;
  assign cfg_wr   = psel & penable & pwrite;
  assign cfg_idx  = reg_idx_t'(paddr[CFG_ADDR_W-1:2]);
  assign wr_pct   = pwdata[PCT_W-1:0];

  always_comb begin
    if (wr_pct < MIN_AWAKE) begin
      wr_pct_clamped = MIN_AWAKE;
    end else if (wr_pct > MAX_AWAKE) begin
      wr_pct_clamped = MAX_AWAKE;
    end else begin
      wr_pct_clamped = wr_pct;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dim_after_r <= DIM_AFTER_RESET;
      off_after_r <= OFF_AFTER_RESET;
      awake_pct_r <= AWAKE_RESET;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_DIM_AFTER: dim_after_r <= pwdata[TICK_W-1:0];
        REG_OFF_AFTER: off_after_r <= pwdata[TICK_W-1:0];
        REG_AWAKE_PCT: awake_pct_r <= wr_pct_clamped;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_DIM_AFTER: prdata = {{(CFG_DATA_W-TICK_W){1'b0}}, dim_after_r};
      REG_OFF_AFTER: prdata = {{(CFG_DATA_W-TICK_W){1'b0}}, off_after_r};
      REG_AWAKE_PCT: prdata = {{(CFG_DATA_W-PCT_W){1'b0}}, awake_pct_r};
      default:       prdata = '0;
    endcase
  end

  // two-stage flow: input register, then result register
  assign advance  = s1_valid_r & (~out_valid_r | out_ready);
  assign in_ready = ~s1_valid_r | advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_ready) begin
        s1_valid_r <= in_valid;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_data_r <= in_data;
    end
    if (advance) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // evaluation of the item in the input register
  assign idle_inc   = (idle_r == IDLE_MAX) ? idle_r : idle_r + 16'd1;
  assign below_dim  = idle_inc < dim_after_r;
  assign below_off  = idle_inc < off_after_r;
  assign stay_awake = ~s1_data_r.pmic_ok | s1_data_r.usb_power;

  always_comb begin
    if (s1_data_r.pin_wake) begin
      wake_src = WAKE_PIN;
    end else if (s1_data_r.boot_pressed) begin
      wake_src = WAKE_BOOT;
    end else if (s1_data_r.pmic_ok && s1_data_r.usb_power && !last_usb_r) begin
      wake_src = WAKE_USB;
    end else begin
      wake_src = WAKE_NONE;
    end
  end

  // next state
  always_comb begin
    mode_nxt     = mode_r;
    idle_nxt     = idle_r;
    last_usb_nxt = last_usb_r;
    unique case (mode_r)
      MODE_SLEEPING: begin
        if (!s1_data_r.cmd) begin
          if (wake_src != WAKE_NONE) begin
            mode_nxt     = MODE_BRIGHT;
            idle_nxt     = '0;
            last_usb_nxt = 1'b0;
          end else if (s1_data_r.pmic_ok) begin
            last_usb_nxt = s1_data_r.usb_power;
          end
        end
      end
      default: begin
        if (s1_data_r.cmd) begin
          idle_nxt = '0;
          mode_nxt = MODE_BRIGHT;
        end else begin
          idle_nxt = idle_inc;
          if (below_dim) begin
            mode_nxt = MODE_BRIGHT;
          end else if (below_off) begin
            if (mode_r == MODE_BRIGHT) begin
              mode_nxt = MODE_DIMMED;
            end
          end else if (stay_awake) begin
            mode_nxt = MODE_OFF;
          end else begin
            mode_nxt     = MODE_SLEEPING;
            last_usb_nxt = 1'b0;
          end
        end
      end
    endcase
  end

  // result fields
  always_comb begin
    res = '0;
    unique case (mode_r)
      MODE_SLEEPING: begin
        if (!s1_data_r.cmd && wake_src != WAKE_NONE) begin
          res.save_request    = 1'b1;
          res.restart_request = 1'b1;
          res.wake_source     = wake_src;
        end
      end
      default: begin
        if (s1_data_r.cmd || below_dim) begin
          if (mode_r != MODE_BRIGHT) begin
            res.brightness       = awake_pct_r;
            res.brightness_write = 1'b1;
          end
        end else if (below_off) begin
          if (mode_r == MODE_BRIGHT) begin
            res.brightness       = DIM_LEVEL;
            res.brightness_write = 1'b1;
          end
        end else begin
          res.save_request     = ~stay_awake;
          res.brightness_write = (mode_r != MODE_OFF);
        end
      end
    endcase
    res.dozing = (mode_nxt == MODE_OFF) || (mode_nxt == MODE_SLEEPING);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r     <= MODE_BRIGHT;
      idle_r     <= '0;
      last_usb_r <= 1'b0;
    end else if (advance) begin
      mode_r     <= mode_nxt;
      idle_r     <= idle_nxt;
      last_usb_r <= last_usb_nxt;
    end
  end

  // checks
  a_restart_saves: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (!out_data_r.restart_request || out_data_r.save_request))
    else $error("restart without save");

  a_wake_resets: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && res.restart_request) |=> (mode_r == MODE_BRIGHT && idle_r == '0 && !last_usb_r))
    else $error("wake did not reset the state");

  a_bright_only_on_write: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_data_r.brightness_write) |-> (out_data_r.brightness == '0))
    else $error("brightness without write strobe");

  a_awake_range: assert property (@(posedge clk) disable iff (!rst_n)
    (awake_pct_r >= MIN_AWAKE) && (awake_pct_r <= MAX_AWAKE))
    else $error("awake brightness out of range");

  a_restart_clears_dozing: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.restart_request) |->
      (!out_data_r.dozing && out_data_r.wake_source != WAKE_NONE))
    else $error("restart result inconsistent");

endmodule
